### design/etpq_pkg.sv
// Shared types and codes for the event time priority queue.
// Used by the cell row and the top level; no dependencies.
package etpq_pkg;

  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_END_TIME = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_END_EN   = 1'b1;

  localparam logic [1:0] ACT_DELTA   = 2'd1;
  localparam int         ACT_POP_BIT = 1;

  typedef enum logic [2:0] {
    ST_EXECUTED = 3'd0,
    ST_DISCARD  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FINISHED = 3'd3,
    ST_SCHED    = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  typedef struct packed {
    logic ins;
    logic pop;
  } etpq_op_t;

endpackage

### design/etpq_if.sv
// Valid/ready channel interfaces for request and result words.
// Standalone; widths come from the parameters of each instance.
interface etpq_in_if #(
  parameter int TIME_BITS   = 48,
  parameter int HANDLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             action;
  logic [TIME_BITS-1:0]   event_time;
  logic [HANDLE_BITS-1:0] event_handle;

  modport source (output valid, action, event_time, event_handle, input ready);
  modport sink   (input valid, action, event_time, event_handle, output ready);
endinterface

interface etpq_out_if #(
  parameter int TIME_BITS   = 48,
  parameter int HANDLE_BITS = 16,
  parameter int CNT_BITS    = 7
);
  logic                   valid;
  logic                   ready;
  logic [2:0]             status;
  logic [HANDLE_BITS-1:0] out_handle;
  logic [TIME_BITS-1:0]   out_time;
  logic [TIME_BITS-1:0]   current_time;
  logic [CNT_BITS-1:0]    queue_count;
  logic [31:0]            late_count;

  modport source (output valid, status, out_handle, out_time, current_time, queue_count,
                  late_count, input ready);
  modport sink   (input valid, status, out_handle, out_time, current_time, queue_count,
                  late_count, output ready);
endinterface

### design/etpq_cell.sv
// One slot of the sorted event row: holds a time and a handle.
// Depends on etpq_pkg for the operation struct.
module etpq_cell #(
  parameter int TIME_BITS   = 48,
  parameter int HANDLE_BITS = 16
) (
  input  logic                   clk_i,
  input  etpq_pkg::etpq_op_t     op_i,
  input  logic                   occupied_i,
  input  logic [TIME_BITS-1:0]   new_time_i,
  input  logic [HANDLE_BITS-1:0] new_handle_i,
  input  logic                   prev_after_i,
  input  logic [TIME_BITS-1:0]   prev_time_i,
  input  logic [HANDLE_BITS-1:0] prev_handle_i,
  input  logic [TIME_BITS-1:0]   next_time_i,
  input  logic [HANDLE_BITS-1:0] next_handle_i,
  output logic                   after_o,
  output logic [TIME_BITS-1:0]   time_o,
  output logic [HANDLE_BITS-1:0] handle_o
);
  import etpq_pkg::*;

  logic [TIME_BITS-1:0]   time_q, time_d;
  logic [HANDLE_BITS-1:0] handle_q, handle_d;

  // An event with an equal time stays ahead of the new one.
  assign after_o = occupied_i && (time_q <= new_time_i);

  always_comb begin
    time_d   = time_q;
    handle_d = handle_q;
    if (op_i.pop) begin
      time_d   = next_time_i;
      handle_d = next_handle_i;
    end else if (op_i.ins && !after_o) begin
      if (prev_after_i) begin
        time_d   = new_time_i;
        handle_d = new_handle_i;
      end else begin
        time_d   = prev_time_i;
        handle_d = prev_handle_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    time_q   <= time_d;
    handle_q <= handle_d;
  end

  assign time_o   = time_q;
  assign handle_o = handle_q;

endmodule

### design/event_time_priority_queue.sv
// Event time priority queue: a row of QUEUE_DEPTH cells kept sorted by time, earliest in
// cell 0. Each request word goes through two states: S_IDLE accepts it and forms its event
// time (an absolute time or the current time plus a saturating delta), and S_EXEC lets the
// cell row insert in place, shift everything one cell toward the head, or stay unchanged.
// An untaken earlier result holds S_EXEC. Configuration is written through cfg_we_i, cfg_idx_i,
// cfg_data_i. Depends on etpq_pkg, etpq_if and etpq_cell.
module event_time_priority_queue #(
  parameter int QUEUE_DEPTH = 64,
  parameter int HANDLE_BITS = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [etpq_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [TIME_BITS-1:0]              cfg_data_i,
  etpq_in_if.sink                           evt_i,
  etpq_out_if.source                        res_o
);
  import etpq_pkg::*;

  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e                 state_q, state_d;
  logic                   pop_q;
  logic [TIME_BITS-1:0]   time_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [CNT_BITS-1:0]    count_q, count_d;
  logic [TIME_BITS-1:0]   now_q, now_d;
  logic [31:0]            late_q, late_d;
  logic                   fin_q, fin_d;
  logic [TIME_BITS-1:0]   end_time_q;
  logic                   end_en_q;

  logic                   out_valid_q, out_valid_d;
  status_e                out_status_q, out_status_d;
  logic [HANDLE_BITS-1:0] out_handle_q, out_handle_d;
  logic [TIME_BITS-1:0]   out_time_q, out_time_d;

  logic [TIME_BITS:0]     sum;
  logic [TIME_BITS-1:0]   eff_time;
  logic                   accept, go, full, stop;
  etpq_op_t               op;

  logic [QUEUE_DEPTH-1:0]   after;
  logic [TIME_BITS-1:0]     c_time   [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0]   c_handle [QUEUE_DEPTH];

  assign evt_i.ready = (state_q == S_IDLE);
  assign accept      = evt_i.valid && evt_i.ready;

  assign sum      = {1'b0, now_q} + {1'b0, evt_i.event_time};
  assign eff_time = (evt_i.action == ACT_DELTA) ?
                    (sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0]) : evt_i.event_time;

  assign go   = (state_q == S_EXEC) && (!out_valid_q || res_o.ready);
  assign full = (count_q == CNT_BITS'(QUEUE_DEPTH));
  assign stop = end_en_q && (fin_q || (now_q > end_time_q));

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    now_d        = now_q;
    late_d       = late_q;
    fin_d        = fin_q;
    op           = '0;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_status_d = out_status_q;
    out_handle_d = out_handle_q;
    out_time_d   = out_time_q;
    if (accept) begin
      state_d = S_EXEC;
    end
    if (go) begin
      state_d      = S_IDLE;
      out_valid_d  = 1'b1;
      out_handle_d = '0;
      out_time_d   = '0;
      if (!pop_q) begin
        out_time_d = time_q;
        if (full) begin
          out_status_d = ST_FULL;
        end else begin
          op.ins       = 1'b1;
          count_d      = count_q + 1'b1;
          out_status_d = ST_SCHED;
        end
      end else if (stop) begin
        out_status_d = ST_FINISHED;
      end else if (count_q == '0) begin
        out_status_d = ST_EMPTY;
      end else begin
        op.pop       = 1'b1;
        count_d      = count_q - 1'b1;
        now_d        = c_time[0];
        out_time_d   = c_time[0];
        out_handle_d = c_handle[0];
        if ((c_time[0] < now_q) && (late_q != '1)) begin
          late_d = late_q + 32'd1;
        end
        if (end_en_q && (c_time[0] > end_time_q)) begin
          fin_d        = 1'b1;
          out_status_d = ST_DISCARD;
        end else begin
          out_status_d = ST_EXECUTED;
        end
      end
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                   prev_after;
    logic [TIME_BITS-1:0]   prev_time, next_time;
    logic [HANDLE_BITS-1:0] prev_handle, next_handle;

    if (i == 0) begin : g_head
      assign prev_after  = 1'b1;
      assign prev_time   = time_q;
      assign prev_handle = handle_q;
    end else begin : g_body
      assign prev_after  = after[i-1];
      assign prev_time   = c_time[i-1];
      assign prev_handle = c_handle[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_time   = '0;
      assign next_handle = '0;
    end else begin : g_mid
      assign next_time   = c_time[i+1];
      assign next_handle = c_handle[i+1];
    end

    etpq_cell #(
      .TIME_BITS  (TIME_BITS),
      .HANDLE_BITS(HANDLE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .op_i         (op),
      .occupied_i   (CNT_BITS'(i) < count_q),
      .new_time_i   (time_q),
      .new_handle_i (handle_q),
      .prev_after_i (prev_after),
      .prev_time_i  (prev_time),
      .prev_handle_i(prev_handle),
      .next_time_i  (next_time),
      .next_handle_i(next_handle),
      .after_o      (after[i]),
      .time_o       (c_time[i]),
      .handle_o     (c_handle[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      now_q       <= '0;
      late_q      <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      end_time_q  <= '1;
      end_en_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      now_q       <= now_d;
      late_q      <= late_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_END_TIME: end_time_q <= cfg_data_i;
          CFG_END_EN:   end_en_q   <= cfg_data_i[0];
          default:      end_en_q   <= end_en_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pop_q    <= evt_i.action[ACT_POP_BIT];
      time_q   <= eff_time;
      handle_q <= evt_i.event_handle;
    end
    out_status_q <= out_status_d;
    out_handle_q <= out_handle_d;
    out_time_q   <= out_time_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.status       = out_status_q;
  assign res_o.out_handle   = out_handle_q;
  assign res_o.out_time     = out_time_q;
  assign res_o.current_time = now_q;
  assign res_o.queue_count  = count_q;
  assign res_o.late_count   = late_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC))
    else $error("result raised without an executing request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && out_valid_q && !res_o.ready) |=> (state_q == S_EXEC))
    else $error("request executed over an untaken result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> $stable(count_q) && $stable(now_q) && $stable(late_q))
    else $error("queue state changed while idle");

endmodule
